[design/ppu_pkg.sv]
// Shared types and constants for the particle pool update block.
package ppu_pkg;

  localparam int PARTICLES_DEF = 64;
  localparam int SLOT_W        = 6;
  localparam int DATA_W        = 32;
  localparam int TS_W          = 16;
  localparam int RAND_W        = 16;
  localparam int LIFE_IN_W     = 31;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  // 2*pi and 0.01 in fixed point
  localparam int TWO_PI_W = 19;
  localparam logic [TWO_PI_W-1:0] TWO_PI_Q16 = 19'd411775;
  localparam int SPIN_W = 10;
  localparam logic [SPIN_W-1:0] SPIN_Q16 = 10'd655;

  typedef enum logic {
    OP_TICK,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [TS_W-1:0]          delta_t;
    logic signed [DATA_W-1:0] start_x;
    logic signed [DATA_W-1:0] start_y;
    logic signed [DATA_W-1:0] base_vel_x;
    logic signed [DATA_W-1:0] base_vel_y;
    logic signed [DATA_W-1:0] spread_x;
    logic signed [DATA_W-1:0] spread_y;
    logic [LIFE_IN_W-1:0]     lifespan;
    logic [RAND_W-1:0]        rand_angle;
    logic [RAND_W-1:0]        rand_x;
    logic [RAND_W-1:0]        rand_y;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] angle;
    logic [DATA_W-1:0] life;
  } res_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EMIT_MUL,
    B_EMIT_WR,
    B_SWEEP,
    B_DRAIN,
    B_FLUSH
  } bstate_t;

endpackage

[design/ppu_front.sv]
// Front end: accepts items, decodes the command and queues them for the back end.
module ppu_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_command,
  input  logic [ppu_pkg::TS_W-1:0]              in_delta_t,
  input  logic signed [ppu_pkg::DATA_W-1:0]     in_start_x,
  input  logic signed [ppu_pkg::DATA_W-1:0]     in_start_y,
  input  logic signed [ppu_pkg::DATA_W-1:0]     in_base_vel_x,
  input  logic signed [ppu_pkg::DATA_W-1:0]     in_base_vel_y,
  input  logic signed [ppu_pkg::DATA_W-1:0]     in_spread_x,
  input  logic signed [ppu_pkg::DATA_W-1:0]     in_spread_y,
  input  logic [ppu_pkg::LIFE_IN_W-1:0]         in_lifespan,
  input  logic [ppu_pkg::RAND_W-1:0]            in_rand_angle,
  input  logic [ppu_pkg::RAND_W-1:0]            in_rand_x,
  input  logic [ppu_pkg::RAND_W-1:0]            in_rand_y,
  output logic                                  q_valid,
  output ppu_pkg::cmd_t                         q_cmd,
  input  logic                                  q_pop
);

  ppu_pkg::cmd_t                   fifo_r [ppu_pkg::QDEPTH];
  logic [ppu_pkg::PTR_W-1:0]       wr_ptr_r;
  logic [ppu_pkg::PTR_W-1:0]       rd_ptr_r;
  logic [ppu_pkg::CNT_W-1:0]       count_r;
  logic [ppu_pkg::CNT_W-1:0]       count_nxt;
  logic                            push;
  ppu_pkg::cmd_t                   cmd_in;

  assign in_ready = (count_r != ppu_pkg::CNT_W'(ppu_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_cmd    = fifo_r[rd_ptr_r];

  always_comb begin
    cmd_in            = '0;
    cmd_in.op         = in_command ? ppu_pkg::OP_EMIT : ppu_pkg::OP_TICK;
    cmd_in.delta_t    = in_delta_t;
    cmd_in.start_x    = in_start_x;
    cmd_in.start_y    = in_start_y;
    cmd_in.base_vel_x = in_base_vel_x;
    cmd_in.base_vel_y = in_base_vel_y;
    cmd_in.spread_x   = in_spread_x;
    cmd_in.spread_y   = in_spread_y;
    cmd_in.lifespan   = in_lifespan;
    cmd_in.rand_angle = in_rand_angle;
    cmd_in.rand_x     = in_rand_x;
    cmd_in.rand_y     = in_rand_y;
  end

  always_comb begin
    case ({push, q_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ppu_pkg::PTR_W'(wr_ptr_r + 1'b1);
      end
      if (q_pop) begin
        rd_ptr_r <= ppu_pkg::PTR_W'(rd_ptr_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

[design/ppu_back.sv]
// Back end: particle stores, emit writer, tick sweep pipeline and result buffering.
module ppu_back #(
  parameter int PARTICLES = ppu_pkg::PARTICLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  ppu_pkg::cmd_t                     q_cmd,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ppu_pkg::SLOT_W-1:0]        out_slot,
  output logic signed [ppu_pkg::DATA_W-1:0] out_cur_x,
  output logic signed [ppu_pkg::DATA_W-1:0] out_cur_y,
  output logic signed [ppu_pkg::DATA_W-1:0] out_angle,
  output logic signed [ppu_pkg::DATA_W-1:0] out_life_left,
  output logic                              out_last
);

  localparam int IDX_W = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTICLES - 1);
  localparam int DW    = ppu_pkg::DATA_W;
  localparam int PW    = DW + ppu_pkg::TS_W + 1;      // velocity * time step
  localparam int EW    = DW + ppu_pkg::RAND_W;        // spread * centred random
  localparam int AW    = ppu_pkg::TWO_PI_W + ppu_pkg::RAND_W;
  localparam int SPW   = ppu_pkg::SPIN_W + ppu_pkg::TS_W;

  ppu_pkg::bstate_t state_r, state_nxt;
  ppu_pkg::cmd_t    cur_r;
  logic [ppu_pkg::SPIN_W-1:0] spin_r;
  logic [IDX_W-1:0]  next_slot_r;
  logic [PARTICLES-1:0] alive_r;
  logic [IDX_W-1:0]  issue_idx_r;

  logic [DW-1:0] mem_px [PARTICLES];
  logic [DW-1:0] mem_py [PARTICLES];
  logic [DW-1:0] mem_vx [PARTICLES];
  logic [DW-1:0] mem_vy [PARTICLES];
  logic [DW-1:0] mem_ang [PARTICLES];
  logic [DW-1:0] mem_life [PARTICLES];

  // stage 1: memory read data
  logic             s1_v_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s1_alive_r;
  logic [DW-1:0]    rd_px_r, rd_py_r, rd_vx_r, rd_vy_r, rd_ang_r, rd_life_r;

  // stage 2: products and classification
  logic                 s2_v_r;
  logic [IDX_W-1:0]     s2_idx_r;
  logic                 s2_live_r;
  logic                 s2_kill_r;
  logic signed [PW-1:0] s2_dx_r, s2_dy_r;
  logic [DW-1:0]        s2_px_r, s2_py_r, s2_ang_r, s2_life_r;

  // emit products
  logic signed [EW-1:0] em_dvx_r, em_dvy_r;
  logic [AW-1:0]        em_ang_r;
  logic signed [ppu_pkg::RAND_W-1:0] rnd_x, rnd_y;

  ppu_pkg::res_t hold_r, out_r, res_new;
  logic          hold_v_r, out_v_r, out_last_r;

  logic adv, issue, report, kill, em_we, sw_we, flush_push;
  logic life_le0;
  logic [IDX_W-1:0] slot_dec;
  logic [DW-1:0]    em_vx, em_vy, em_ang, em_life;

  assign adv        = !out_v_r || out_ready;
  assign issue      = (state_r == ppu_pkg::B_SWEEP) && adv;
  assign report     = s2_v_r && s2_live_r && adv;
  assign kill       = s2_v_r && s2_kill_r && adv;
  assign em_we      = (state_r == ppu_pkg::B_EMIT_WR);
  assign sw_we      = report;
  assign flush_push = (state_r == ppu_pkg::B_FLUSH) && hold_v_r && adv;

  assign life_le0 = rd_life_r[DW-1] || (rd_life_r == '0);
  assign slot_dec = (next_slot_r == '0) ? LAST_IDX : IDX_W'(next_slot_r - 1'b1);

  // rand - 0.5 as signed Q0.16
  assign rnd_x = $signed({~cur_r.rand_x[ppu_pkg::RAND_W-1], cur_r.rand_x[ppu_pkg::RAND_W-2:0]});
  assign rnd_y = $signed({~cur_r.rand_y[ppu_pkg::RAND_W-1], cur_r.rand_y[ppu_pkg::RAND_W-2:0]});

  assign em_vx   = cur_r.base_vel_x + em_dvx_r[EW-1:16];
  assign em_vy   = cur_r.base_vel_y + em_dvy_r[EW-1:16];
  assign em_ang  = DW'(em_ang_r[AW-1:16]);
  assign em_life = {1'b0, cur_r.lifespan};

  always_comb begin
    res_new.slot  = ppu_pkg::SLOT_W'(s2_idx_r);
    res_new.x     = s2_px_r + s2_dx_r[DW+15:16];
    res_new.y     = s2_py_r + s2_dy_r[DW+15:16];
    res_new.angle = s2_ang_r + DW'(spin_r);
    res_new.life  = s2_life_r - DW'(cur_r.delta_t);
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      ppu_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = (q_cmd.op == ppu_pkg::OP_EMIT) ? ppu_pkg::B_EMIT_MUL : ppu_pkg::B_SWEEP;
        end
      end
      ppu_pkg::B_EMIT_MUL: state_nxt = ppu_pkg::B_EMIT_WR;
      ppu_pkg::B_EMIT_WR:  state_nxt = ppu_pkg::B_IDLE;
      ppu_pkg::B_SWEEP: begin
        if (adv && issue_idx_r == LAST_IDX) begin
          state_nxt = ppu_pkg::B_DRAIN;
        end
      end
      ppu_pkg::B_DRAIN: begin
        if (!s1_v_r && !s2_v_r) begin
          state_nxt = ppu_pkg::B_FLUSH;
        end
      end
      ppu_pkg::B_FLUSH: begin
        if (!hold_v_r || adv) begin
          state_nxt = ppu_pkg::B_IDLE;
        end
      end
      default: state_nxt = ppu_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppu_pkg::B_IDLE;
      next_slot_r <= LAST_IDX;
      alive_r     <= '0;
      issue_idx_r <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      hold_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        issue_idx_r <= '0;
      end else if (issue) begin
        issue_idx_r <= IDX_W'(issue_idx_r + 1'b1);
      end
      if (adv) begin
        s1_v_r <= issue;
        s2_v_r <= s1_v_r;
      end
      if (em_we) begin
        alive_r[next_slot_r] <= 1'b1;
        next_slot_r          <= slot_dec;
      end
      if (kill) begin
        alive_r[s2_idx_r] <= 1'b0;
      end
      // hold the newest result back until it is known whether it ends the tick
      if (flush_push) begin
        out_v_r  <= 1'b1;
        hold_v_r <= 1'b0;
      end else if (report) begin
        out_v_r  <= hold_v_r;
        hold_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r  <= q_cmd;
      spin_r <= ppu_pkg::SPIN_W'((SPW'(q_cmd.delta_t) * SPW'(ppu_pkg::SPIN_Q16)) >> 16);
    end
    if (state_r == ppu_pkg::B_EMIT_MUL) begin
      em_dvx_r <= $signed(cur_r.spread_x) * rnd_x;
      em_dvy_r <= $signed(cur_r.spread_y) * rnd_y;
      em_ang_r <= AW'(cur_r.rand_angle) * AW'(ppu_pkg::TWO_PI_Q16);
    end
    if (adv) begin
      s1_idx_r   <= issue_idx_r;
      s1_alive_r <= alive_r[issue_idx_r];
      s2_idx_r   <= s1_idx_r;
      s2_live_r  <= s1_alive_r && !life_le0;
      s2_kill_r  <= s1_alive_r && life_le0;
      s2_dx_r    <= $signed(rd_vx_r) * $signed({1'b0, cur_r.delta_t});
      s2_dy_r    <= $signed(rd_vy_r) * $signed({1'b0, cur_r.delta_t});
      s2_px_r    <= rd_px_r;
      s2_py_r    <= rd_py_r;
      s2_ang_r   <= rd_ang_r;
      s2_life_r  <= rd_life_r;
    end
    if (flush_push) begin
      out_r      <= hold_r;
      out_last_r <= 1'b1;
    end else if (report) begin
      hold_r <= res_new;
      if (hold_v_r) begin
        out_r      <= hold_r;
        out_last_r <= 1'b0;
      end
    end
  end

  // particle stores: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (em_we) begin
      mem_px[next_slot_r]   <= cur_r.start_x;
      mem_py[next_slot_r]   <= cur_r.start_y;
      mem_vx[next_slot_r]   <= em_vx;
      mem_vy[next_slot_r]   <= em_vy;
      mem_ang[next_slot_r]  <= em_ang;
      mem_life[next_slot_r] <= em_life;
    end else if (sw_we) begin
      mem_px[s2_idx_r]   <= res_new.x;
      mem_py[s2_idx_r]   <= res_new.y;
      mem_ang[s2_idx_r]  <= res_new.angle;
      mem_life[s2_idx_r] <= res_new.life;
    end
    if (issue) begin
      rd_px_r   <= mem_px[issue_idx_r];
      rd_py_r   <= mem_py[issue_idx_r];
      rd_vx_r   <= mem_vx[issue_idx_r];
      rd_vy_r   <= mem_vy[issue_idx_r];
      rd_ang_r  <= mem_ang[issue_idx_r];
      rd_life_r <= mem_life[issue_idx_r];
    end
  end

  assign out_valid     = out_v_r;
  assign out_slot      = out_r.slot;
  assign out_cur_x     = out_r.x;
  assign out_cur_y     = out_r.y;
  assign out_angle     = out_r.angle;
  assign out_life_left = out_r.life;
  assign out_last      = out_last_r;

endmodule

[design/particle_pool_update_top.sv]
// Top level of the particle pool update block.
//
// Input channel (in_valid/in_ready): one item is either an emit (in_command = 1)
// or a tick (in_command = 0). An emit writes the slot at the ring index, which
// starts at PARTICLES-1 and counts down with wrap, and returns no result.
// A tick retires expired particles and advances every other live one, giving
// one result per live particle on the out_ channel in ascending slot order,
// with out_last on the final one. A tick with nothing live gives no result.
// An emit occupies the back end through B_EMIT_MUL and B_EMIT_WR; a tick
// through B_SWEEP, B_DRAIN and B_FLUSH, the sweep reading one slot per cycle
// from the particle stores while the receiver does not stall. The back end
// takes no new item until it is back in B_IDLE. Each result is held one slot
// back so that out_last can be set.
// A two-entry command queue lets the input side keep accepting while the
// back end sweeps. When the receiver stalls, the whole sweep pipeline holds
// and the output payload stays put.
// Reset (rst_n, synchronous) marks every slot inactive, sets the ring index to
// PARTICLES-1 and empties the queue; no clearing pass is needed.
module particle_pool_update_top #(
  parameter int PARTICLES = ppu_pkg::PARTICLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_command,
  input  logic [ppu_pkg::TS_W-1:0]          in_delta_t,
  input  logic signed [ppu_pkg::DATA_W-1:0] in_start_x,
  input  logic signed [ppu_pkg::DATA_W-1:0] in_start_y,
  input  logic signed [ppu_pkg::DATA_W-1:0] in_base_vel_x,
  input  logic signed [ppu_pkg::DATA_W-1:0] in_base_vel_y,
  input  logic signed [ppu_pkg::DATA_W-1:0] in_spread_x,
  input  logic signed [ppu_pkg::DATA_W-1:0] in_spread_y,
  input  logic [ppu_pkg::LIFE_IN_W-1:0]     in_lifespan,
  input  logic [ppu_pkg::RAND_W-1:0]        in_rand_angle,
  input  logic [ppu_pkg::RAND_W-1:0]        in_rand_x,
  input  logic [ppu_pkg::RAND_W-1:0]        in_rand_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ppu_pkg::SLOT_W-1:0]        out_slot,
  output logic signed [ppu_pkg::DATA_W-1:0] out_cur_x,
  output logic signed [ppu_pkg::DATA_W-1:0] out_cur_y,
  output logic signed [ppu_pkg::DATA_W-1:0] out_angle,
  output logic signed [ppu_pkg::DATA_W-1:0] out_life_left,
  output logic                              out_last
);

  logic          q_valid;
  logic          q_pop;
  ppu_pkg::cmd_t q_cmd;

  ppu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_delta_t    (in_delta_t),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_base_vel_x (in_base_vel_x),
    .in_base_vel_y (in_base_vel_y),
    .in_spread_x   (in_spread_x),
    .in_spread_y   (in_spread_y),
    .in_lifespan   (in_lifespan),
    .in_rand_angle (in_rand_angle),
    .in_rand_x     (in_rand_x),
    .in_rand_y     (in_rand_y),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  ppu_back #(
    .PARTICLES (PARTICLES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_slot      (out_slot),
    .out_cur_x     (out_cur_x),
    .out_cur_y     (out_cur_y),
    .out_angle     (out_angle),
    .out_life_left (out_life_left),
    .out_last      (out_last)
  );

endmodule

[design/ppu_checker.sv]
// Port-level checks for the particle pool update block, bound to the top level.
module ppu_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [ppu_pkg::SLOT_W-1:0]        out_slot,
  input logic signed [ppu_pkg::DATA_W-1:0] out_cur_x,
  input logic                              out_last
);

  logic                       mid_tick_r;
  logic [ppu_pkg::SLOT_W-1:0] prev_slot_r;

  // track whether a tick's result stream is under way
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_tick_r  <= 1'b0;
      prev_slot_r <= '0;
    end else if (out_valid && out_ready) begin
      mid_tick_r  <= !out_last;
      prev_slot_r <= out_slot;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && mid_tick_r) |-> (out_slot > prev_slot_r))
    else $error("results of one tick not in ascending slot order");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      ($stable(out_slot) && $stable(out_cur_x) && $stable(out_last)))
    else $error("result payload changed while stalled");

endmodule

bind particle_pool_update_top ppu_checker u_ppu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_slot  (out_slot),
  .out_cur_x (out_cur_x),
  .out_last  (out_last)
);
